@@ design/albs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// albs_pkg - shared types and constants for the ambient light brightness slew
// Register indexes, fixed field widths and the sequencer state type.
// ----------------------------------------------------------------------------
package albs_pkg;

  localparam int SAMPLE_W    = 10;
  localparam int LEVEL_OUT_W = 5;
  localparam int MIN_W       = 5;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 10;

  localparam logic [CFG_INDEX_W-1:0] REG_SENSOR_ENABLE  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_BRIGHTNESS = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD_0    = 3'd2;
  localparam int                     NUM_THRESHOLD_REGS = 4;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 10'd1023;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_MEAN,
    ST_THR_SCAN,
    ST_SCALE,
    ST_QUOT_GO,
    ST_QUOT_WAIT,
    ST_TARGET,
    ST_EMIT
  } albs_state_t;

endpackage

@@ design/albs_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// albs_div - restoring divider, one quotient bit per cycle
// Captures operands on start, raises done on the cycle of its last step.
// ----------------------------------------------------------------------------
module albs_div #(
  parameter int DVD_W = 13,
  parameter int DVS_W = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DVD_W - 1);

  logic             busy;
  logic [CNT_W-1:0] count;
  logic [DVD_W-1:0] quo;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;

  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic [DVD_W-1:0] quo_next;
  logic [DVS_W-1:0] rem_next;

  always_comb begin
    trial = {rem, quo[DVD_W-1]};
    diff  = trial - {1'b0, dvs};
    if (!diff[DVS_W]) begin
      rem_next = diff[DVS_W-1:0];
      quo_next = {quo[DVD_W-2:0], 1'b1};
    end else begin
      rem_next = trial[DVS_W-1:0];
      quo_next = {quo[DVD_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= '0;
    end else if (busy) begin
      count <= count + 1'b1;
      if (count == LAST_STEP) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign done     = busy && (count == LAST_STEP);
  assign quotient = quo;

endmodule

@@ design/ambient_light_brightness_slew.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ambient_light_brightness_slew - light sensor driven display dimmer
// Averages the recent sensor samples, maps the mean onto a brightness target
// through a threshold ladder and slews the output level one step per sample.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid / in_stall take one light_sample word; in_stall stays high from
//   the take until the result is loaded into the output register.
//   out_valid / out_stall carry brightness_level, target_level and
//   average_light; a stalled result word holds, and the next sample may be
//   taken while it waits.
//   Each take runs through read, ring update, mean, a threshold scan that
//   visits each threshold in turn, scale, the divider for the target
//   scaling, target and emit; the divider is skipped when the sensor is off
//   or the floor is at or above LEVELS. A load waiting on a stalled earlier
//   word waits out the stall. One sample is in work at a time; the next is
//   taken once the last result is loaded. Reset clears the config and control
//   registers, marks every ring entry as full scale, starts the write position
//   at zero and the level at the top; no clearing pass.
//   Configuration: cfg_we with cfg_index / cfg_data, written only while idle.
// ----------------------------------------------------------------------------
module ambient_light_brightness_slew
  import albs_pkg::*;
#(
  parameter int SAMPLE_COUNT    = 8,
  parameter int LEVELS          = 32,
  parameter int THRESHOLD_COUNT = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SAMPLE_W-1:0]    light_sample,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [LEVEL_OUT_W-1:0] brightness_level,
  output logic [LEVEL_OUT_W-1:0] target_level,
  output logic [SAMPLE_W-1:0]    average_light,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // Widths derived from the parameters
  localparam int PTR_W     = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;
  localparam int SUM_MAX   = SAMPLE_COUNT * int'(SAMPLE_MAX);
  localparam int SUM_W     = $clog2(SUM_MAX + 1);
  localparam int LVL_W     = $clog2(LEVELS);
  localparam int CNT_W     = $clog2(THRESHOLD_COUNT + 1);
  localparam int THR_IDX_W = (THRESHOLD_COUNT > 1) ? $clog2(THRESHOLD_COUNT) : 1;
  localparam int DIFF_W    = $clog2(LEVELS + 1);
  localparam int PROD_W    = DIFF_W + CNT_W;
  localparam int DVD_W     = PROD_W;
  localparam int DVS_W     = CNT_W;
  localparam int TS_W      = ((DIFF_W > MIN_W) ? DIFF_W : MIN_W) + 1;

  // Mean by reciprocal multiply: exact for every sum below 2**SUM_W
  localparam int     REC_SHIFT = SUM_W + $clog2(SAMPLE_COUNT);
  localparam int     REC_W     = SUM_W + 2;
  localparam int     MP_W      = SUM_W + REC_W;
  localparam longint REC_MUL_L = ((longint'(1) << REC_SHIFT) + longint'(SAMPLE_COUNT) - 1)
                                 / longint'(SAMPLE_COUNT);
  localparam logic [REC_W-1:0] REC_MUL = REC_W'(REC_MUL_L);

  localparam logic [PTR_W-1:0]     LAST_POS = PTR_W'(SAMPLE_COUNT - 1);
  localparam logic [THR_IDX_W-1:0] LAST_THR = THR_IDX_W'(THRESHOLD_COUNT - 1);
  localparam logic [LVL_W-1:0]     TOP_LVL  = LVL_W'(LEVELS - 1);

  // Configuration registers
  logic                sensor_enable;
  logic [MIN_W-1:0]    min_brightness;
  logic [SAMPLE_W-1:0] thr [THRESHOLD_COUNT];

  // Sample ring and running sum
  logic [SAMPLE_W-1:0]     ring [SAMPLE_COUNT];
  logic [SAMPLE_COUNT-1:0] ring_valid;
  logic [SAMPLE_W-1:0]     rd_data;
  logic [PTR_W-1:0]        wr_pos;
  logic [PTR_W-1:0]        pos_inc;
  logic [SAMPLE_W-1:0]     sample;
  logic [SAMPLE_W-1:0]     old_sample;
  logic [SUM_W-1:0]        sum;
  logic [SUM_W-1:0]        sum_next;
  logic [MP_W-1:0]         mean_prod;

  // Threshold scan
  logic [THR_IDX_W-1:0] thr_idx;
  logic [SAMPLE_W-1:0]  prev_thr;
  logic [SAMPLE_W-1:0]  cur_thr;
  logic [CNT_W-1:0]     reached;
  logic [CNT_W-1:0]     defined;
  logic [SAMPLE_W-1:0]  mean;
  logic [SAMPLE_W-1:0]  quo_mean;

  // Target and level
  logic              force_top;
  logic [PROD_W-1:0] prod;
  logic [DIFF_W-1:0] level_gap;
  logic              min_at_top;
  logic [TS_W-1:0]   tsum;
  logic [LVL_W-1:0]  target;
  logic [LVL_W-1:0]  level;
  logic [LVL_W-1:0]  level_next;

  // Sequencer and divider
  albs_state_t       state;
  albs_state_t       state_next;
  logic              out_free;
  logic              div_start;
  logic              div_done;
  logic [DVD_W-1:0]  div_dividend;
  logic [DVS_W-1:0]  div_divisor;
  logic [DVD_W-1:0]  div_quo;

  // --------------------------------------------------------------------------
  // Configuration writes
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_enable  <= 1'b0;
      min_brightness <= '0;
      for (int j = 0; j < THRESHOLD_COUNT; j++) begin
        thr[j] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == REG_SENSOR_ENABLE) begin
        sensor_enable <= cfg_data[0];
      end
      if (cfg_index == REG_MIN_BRIGHTNESS) begin
        min_brightness <= cfg_data[MIN_W-1:0];
      end
      // Thresholds past the register file stay at zero
      for (int j = 0; j < THRESHOLD_COUNT; j++) begin
        if (j < NUM_THRESHOLD_REGS &&
            cfg_index == REG_THRESHOLD_0 + CFG_INDEX_W'(j)) begin
          thr[j] <= cfg_data[SAMPLE_W-1:0];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Divider: gap * reached / defined for the target scaling
  // --------------------------------------------------------------------------
  albs_div #(
    .DVD_W(DVD_W),
    .DVS_W(DVS_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  // --------------------------------------------------------------------------
  // Datapath helpers
  // --------------------------------------------------------------------------
  // Advance the write position, wrapping at the ring size
  assign pos_inc = (wr_pos == LAST_POS) ? '0 : wr_pos + 1'b1;

  // Entries never written still hold full scale
  assign old_sample = ring_valid[wr_pos] ? rd_data : SAMPLE_MAX;
  assign sum_next   = sum - SUM_W'(old_sample) + SUM_W'(sample);

  // Truncated mean of the running sum
  assign mean_prod = MP_W'(sum) * MP_W'(REC_MUL);
  assign quo_mean  = SAMPLE_W'(mean_prod >> REC_SHIFT);

  assign cur_thr  = thr[thr_idx];

  // A minimum at or above LEVELS always lands on the top level
  assign min_at_top = int'(min_brightness) >= LEVELS;
  assign level_gap  = DIFF_W'(LEVELS - int'(min_brightness));
  assign tsum       = TS_W'(min_brightness) + TS_W'(div_quo);

  always_comb begin
    if (level > target) begin
      level_next = level - 1'b1;
    end else if (level < target) begin
      level_next = level + 1'b1;
    end else begin
      level_next = level;
    end
  end

  assign out_free = !out_valid || !out_stall;

  // --------------------------------------------------------------------------
  // Sequencer state register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, handshake and divider operand selection
  always_comb begin
    state_next   = state;
    in_stall     = 1'b1;
    div_start    = 1'b0;
    div_dividend = prod;
    div_divisor  = defined;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_next = ST_MEAN;
      end
      ST_MEAN: begin
        state_next = ST_THR_SCAN;
      end
      ST_THR_SCAN: begin
        if (thr_idx == LAST_THR) begin
          state_next = ST_SCALE;
        end
      end
      ST_SCALE: begin
        if (!sensor_enable || min_at_top) begin
          state_next = ST_TARGET;
        end else begin
          state_next = ST_QUOT_GO;
        end
      end
      ST_QUOT_GO: begin
        div_start  = 1'b1;
        state_next = ST_QUOT_WAIT;
      end
      ST_QUOT_WAIT: begin
        if (div_done) begin
          state_next = ST_TARGET;
        end
      end
      ST_TARGET: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Ring memory: registered read at the write position, write on update
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (state == ST_UPDATE) begin
      ring[wr_pos] <= sample;
    end
    rd_data <= ring[wr_pos];
  end

  // --------------------------------------------------------------------------
  // Control state: ring bookkeeping, level and output handshake
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_valid <= '0;
      wr_pos     <= '0;
      sum        <= SUM_W'(SUM_MAX);
      level      <= TOP_LVL;
      out_valid  <= 1'b0;
    end else begin
      if (state == ST_IDLE && in_valid) begin
        wr_pos <= pos_inc;
      end
      if (state == ST_UPDATE) begin
        ring_valid[wr_pos] <= 1'b1;
        sum                <= sum_next;
      end
      // Load the next result when the slot is free, drop it once taken
      if (state == ST_EMIT && out_free) begin
        level     <= level_next;
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      sample <= light_sample;
    end
    if (state == ST_MEAN) begin
      mean     <= quo_mean;
      thr_idx  <= '0;
      prev_thr <= '0;
      reached  <= '0;
      defined  <= '0;
    end
    if (state == ST_THR_SCAN) begin
      thr_idx <= thr_idx + 1'b1;
      // A threshold below the last defined one is skipped
      if (cur_thr >= prev_thr) begin
        prev_thr <= cur_thr;
        defined  <= defined + 1'b1;
        if (mean >= cur_thr) begin
          reached <= reached + 1'b1;
        end
      end
    end
    if (state == ST_SCALE) begin
      force_top <= !sensor_enable || min_at_top;
      prod      <= PROD_W'(level_gap) * PROD_W'(reached);
    end
    if (state == ST_TARGET) begin
      // Clamp a negative target to zero; the top cannot be exceeded here
      if (force_top) begin
        target <= TOP_LVL;
      end else if (tsum == '0) begin
        target <= '0;
      end else begin
        target <= LVL_W'(tsum - 1'b1);
      end
    end
    if (state == ST_EMIT && out_free) begin
      brightness_level <= LEVEL_OUT_W'(level_next);
      target_level     <= LEVEL_OUT_W'(target);
      average_light    <= mean;
    end
  end

endmodule

@@ design/albs_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// albs_checker - port-level checks for the brightness slew block
// Watches both channels and the result range; bound to the top level.
// ----------------------------------------------------------------------------
module albs_checker
  import albs_pkg::*;
#(
  parameter int LEVELS = 32
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [LEVEL_OUT_W-1:0] brightness_level,
  input logic [LEVEL_OUT_W-1:0] target_level
);

  // Block is busy right after taking a sample word
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a sample is still in work");

  // A result word never appears in the cycle right after a take
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result word appeared too early");

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(brightness_level)
      && $stable(target_level))
    else $error("stalled result word changed");

  // Levels stay within range
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> int'(brightness_level) <= LEVELS - 1
      && int'(target_level) <= LEVELS - 1)
    else $error("brightness level out of range");

endmodule

bind ambient_light_brightness_slew albs_checker #(
  .LEVELS(LEVELS)
) u_albs_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .brightness_level (brightness_level),
  .target_level     (target_level)
);

@@ verif/tb_ambient_light_brightness_slew.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ambient_light_brightness_slew - self-checking bench for the light dimmer
// Streams light sample words through the block under several register
// settings and idle/stall mixes. A local model of the averaging ring, the
// threshold ladder and the one-step slew predicts every result word, and a
// monitor compares each accepted word field by field.
// ----------------------------------------------------------------------------
module tb_ambient_light_brightness_slew;
  import albs_pkg::*;

  // Block parameters, kept at the defaults of the design.
  localparam int SAMPLES     = 8;
  localparam int LEVEL_COUNT = 32;
  localparam int THR_COUNT   = 4;

  // Each word takes its latency plus any receiver stall. Allow many times
  // that before giving up on a quiet channel.
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 60;
  localparam int RANDOM_PHASES  = 12;
  localparam int PHASE_ITEMS    = 162;

  // Indexes past the last threshold register; the block must ignore them.
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

  // Register setting styles for the random phases.
  typedef enum int {
    CFG_ALL_LOW,
    CFG_ALL_HIGH,
    CFG_LADDER,
    CFG_SCRAMBLED,
    CFG_DISABLED
  } cfg_style_t;

  typedef struct packed {
    logic [LEVEL_OUT_W-1:0] level;
    logic [LEVEL_OUT_W-1:0] target;
    logic [SAMPLE_W-1:0]    mean;
  } dimmer_word_t;

  // --------------------------------------------------------------------------
  // DUT signals; those the bench drives are known from time zero
  // --------------------------------------------------------------------------
  logic                   clk          = 1'b0;
  logic                   rst          = 1'b1;
  logic                   in_valid     = 1'b0;
  logic                   in_stall;
  logic [SAMPLE_W-1:0]    light_sample = '0;
  logic                   out_valid;
  logic                   out_stall    = 1'b0;
  logic [LEVEL_OUT_W-1:0] brightness_level;
  logic [LEVEL_OUT_W-1:0] target_level;
  logic [SAMPLE_W-1:0]    average_light;
  logic                   cfg_we       = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index    = '0;
  logic [CFG_DATA_W-1:0]  cfg_data     = '0;

  ambient_light_brightness_slew #(
    .SAMPLE_COUNT    (SAMPLES),
    .LEVELS          (LEVEL_COUNT),
    .THRESHOLD_COUNT (THR_COUNT)
  ) u_top (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .light_sample     (light_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .brightness_level (brightness_level),
    .target_level     (target_level),
    .average_light    (average_light),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  logic [SAMPLE_W-1:0] pending_samples [$];   // words waiting for the driver
  dimmer_word_t        expected_words  [$];   // predicted results, oldest first

  int idle_pct     = 0;   // chance per cycle that the sender holds off
  int stall_pct    = 0;   // chance per cycle that the receiver stalls
  int errors       = 0;
  int words_in     = 0;
  int words_out    = 0;
  int cfg_writes   = 0;
  int phases_run   = 0;
  int quiet_cycles = 0;

  // Local copy of the dimmer: ring, write position, level and registers.
  logic [SAMPLE_W-1:0] ring_copy [SAMPLES];
  int                  wpos_copy;
  int                  level_copy;
  bit                  enable_copy;
  int                  min_copy;
  logic [SAMPLE_W-1:0] thr_copy [THR_COUNT];

  task automatic clear_dimmer_copy();
    for (int i = 0; i < SAMPLES; i++) ring_copy[i] = SAMPLE_MAX;
    for (int i = 0; i < THR_COUNT; i++) thr_copy[i] = '0;
    wpos_copy   = 0;
    level_copy  = LEVEL_COUNT - 1;
    enable_copy = 1'b0;
    min_copy    = 0;
  endtask

  // Advance the ring, average it, walk the threshold ladder and slew the level
  // one step; queue the word that the block must produce for this sample.
  task automatic predict_dimmer_word(input logic [SAMPLE_W-1:0] sample);
    int           sum;
    int           mean_v;
    int           defined;
    int           reached;
    int           prev;
    int           goal;
    dimmer_word_t w;
    wpos_copy = (wpos_copy + 1) % SAMPLES;
    ring_copy[wpos_copy] = sample;
    sum = 0;
    for (int i = 0; i < SAMPLES; i++) sum += int'(ring_copy[i]);
    mean_v = sum / SAMPLES;
    if (!enable_copy) begin
      goal = LEVEL_COUNT - 1;
    end else begin
      defined = 0;
      reached = 0;
      prev    = 0;
      // A threshold below the last one that counted is skipped entirely.
      for (int i = 0; i < THR_COUNT; i++) begin
        if (int'(thr_copy[i]) >= prev) begin
          prev = int'(thr_copy[i]);
          if (mean_v >= int'(thr_copy[i])) reached++;
          defined++;
        end
      end
      if (defined == 0) defined = 1;
      goal = ((LEVEL_COUNT - min_copy) * reached) / defined;
      goal = min_copy + goal - 1;
      // Nothing reached with a zero floor lands below zero: pin to the bottom.
      if (goal < 0) goal = 0;
      if (goal > LEVEL_COUNT - 1) goal = LEVEL_COUNT - 1;
    end
    if (level_copy > goal) level_copy--;
    else if (level_copy < goal) level_copy++;
    w.level  = LEVEL_OUT_W'(level_copy);
    w.target = LEVEL_OUT_W'(goal);
    w.mean   = SAMPLE_W'(mean_v);
    expected_words.push_back(w);
  endtask

  // --------------------------------------------------------------------------
  // Register port: one write per call, mirrored into the local copy
  // --------------------------------------------------------------------------
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0]  data);
    int k;
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cfg_writes++;
    if (idx == REG_SENSOR_ENABLE) begin
      enable_copy = data[0];
    end else if (idx == REG_MIN_BRIGHTNESS) begin
      min_copy = int'(data[MIN_W-1:0]);
    end else if (idx >= REG_THRESHOLD_0 &&
                 int'(idx) < int'(REG_THRESHOLD_0) + NUM_THRESHOLD_REGS) begin
      // Threshold registers past THRESHOLD_COUNT are dropped by the block.
      k = int'(idx) - int'(REG_THRESHOLD_0);
      if (k < THR_COUNT) thr_copy[k] = data;
    end
  endtask

  task automatic write_thresholds(input logic [CFG_DATA_W-1:0] t0,
                                  input logic [CFG_DATA_W-1:0] t1,
                                  input logic [CFG_DATA_W-1:0] t2,
                                  input logic [CFG_DATA_W-1:0] t3);
    write_reg(REG_THRESHOLD_0,               t0);
    write_reg(CFG_INDEX_W'(REG_THRESHOLD_0 + 1), t1);
    write_reg(CFG_INDEX_W'(REG_THRESHOLD_0 + 2), t2);
    write_reg(CFG_INDEX_W'(REG_THRESHOLD_0 + 3), t3);
  endtask

  // Pick a register setting. Junk in the unused upper data bits of the
  // narrow registers must be ignored, so randomize those bits too.
  task automatic configure_dimmer(input cfg_style_t style);
    logic [CFG_DATA_W-1:0] ladder [NUM_THRESHOLD_REGS];
    logic [CFG_DATA_W-1:0] en_data;
    logic [CFG_DATA_W-1:0] min_data;
    logic [CFG_DATA_W-1:0] swap;
    en_data  = CFG_DATA_W'($urandom);
    min_data = CFG_DATA_W'($urandom);
    case (style)
      CFG_ALL_LOW: begin
        en_data[0] = 1'b1;
        min_data[MIN_W-1:0] = '0;
        foreach (ladder[i]) ladder[i] = '0;
      end
      CFG_ALL_HIGH: begin
        en_data[0] = 1'b1;
        min_data[MIN_W-1:0] = '1;
        foreach (ladder[i]) ladder[i] = '1;
      end
      CFG_LADDER: begin
        en_data[0] = 1'b1;
        foreach (ladder[i]) ladder[i] = CFG_DATA_W'($urandom);
        // Order the ladder so that every threshold counts
        for (int i = 1; i < NUM_THRESHOLD_REGS; i++) begin
          for (int j = i; j > 0 && ladder[j-1] > ladder[j]; j--) begin
            swap        = ladder[j];
            ladder[j]   = ladder[j-1];
            ladder[j-1] = swap;
          end
        end
      end
      CFG_SCRAMBLED: begin
        en_data[0] = 1'b1;
        foreach (ladder[i]) ladder[i] = CFG_DATA_W'($urandom);
      end
      default: begin
        en_data[0] = 1'b0;
        foreach (ladder[i]) ladder[i] = CFG_DATA_W'($urandom);
      end
    endcase
    write_reg(REG_SENSOR_ENABLE, en_data);
    write_reg(REG_MIN_BRIGHTNESS, min_data);
    write_thresholds(ladder[0], ladder[1], ladder[2], ladder[3]);
    if ($urandom_range(3) == 0) write_reg(REG_SPARE_LO, CFG_DATA_W'($urandom));
    if ($urandom_range(3) == 0) write_reg(REG_SPARE_HI, CFG_DATA_W'($urandom));
  endtask

  // Queue sample words in bursts of 16 with one flavor per burst: uniform
  // noise, a cluster near some level, a stuck rail, or a slow drift. The
  // clusters and drifts keep the mean near a chosen base level.
  task automatic queue_samples(input int count);
    int flavor;
    int base;
    int s;
    flavor = 0;
    base   = 0;
    for (int i = 0; i < count; i++) begin
      if (i % 16 == 0) begin
        flavor = $urandom_range(3);
        base   = $urandom_range(1023);
      end
      case (flavor)
        0: s = $urandom_range(1023);
        1: s = base + $urandom_range(64) - 32;
        2: s = base[0] ? 1023 : 0;
        default: begin
          base = base + $urandom_range(40) - 20;
          if (base < 0) base = 0;
          if (base > 1023) base = 1023;
          s = base;
        end
      endcase
      if (s < 0) s = 0;
      if (s > 1023) s = 1023;
      pending_samples.push_back(SAMPLE_W'(s));
    end
  endtask

  // Hold until every queued word has gone in and every result has come out.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_samples.size() != 0 || in_valid || expected_words.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Driver: feed sample words, hold a stalled word, predict on every take
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid     <= 1'b0;
      light_sample <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_dimmer_word(light_sample);
        words_in++;
      end
      // Only move on once the current word is taken or there is none.
      if (!in_valid || !in_stall) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_valid     <= 1'b1;
          light_sample <= pending_samples.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: random receiver stall, check each taken result word
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    dimmer_word_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
      if (out_valid && !out_stall) begin
        words_out++;
        if (expected_words.size() == 0) begin
          $error("unexpected result word: level %0d target %0d mean %0d",
                 brightness_level, target_level, average_light);
          errors++;
        end else begin
          want = expected_words.pop_front();
          if (brightness_level !== want.level) begin
            $error("brightness_level: expected %0d, got %0d", want.level, brightness_level);
            errors++;
          end
          if (target_level !== want.target) begin
            $error("target_level: expected %0d, got %0d", want.target, target_level);
            errors++;
          end
          if (average_light !== want.mean) begin
            $error("average_light: expected %0d, got %0d", want.mean, average_light);
            errors++;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run if no handshake or write happens for too long
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no traffic for %0d cycles", WATCHDOG_LIMIT);
        $display("tb_ambient_light_brightness_slew: FAIL");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: reset, directed words, random phases, drain, verdict
  // --------------------------------------------------------------------------
  initial begin
    cfg_style_t style;
    int         pick;
    clear_dimmer_copy();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: sensor off, so the level must sit at the top.
    pending_samples.push_back(10'd0);
    pending_samples.push_back(10'd1023);
    pending_samples.push_back(10'h2AA);
    wait_drained();
    phases_run++;

    // Even ladder, zero floor: dark samples pull the mean under the first
    // threshold and the target goes negative, so it must pin at zero; then
    // full-scale samples lift the mean back over the first threshold.
    write_reg(REG_SENSOR_ENABLE, 10'd1);
    write_reg(REG_MIN_BRIGHTNESS, 10'd0);
    write_thresholds(10'd256, 10'd512, 10'd768, 10'd1023);
    repeat (8) pending_samples.push_back(10'd0);
    repeat (4) pending_samples.push_back(10'd1023);
    wait_drained();
    phases_run++;

    // Top floor with junk upper bits, an out-of-order ladder so that some
    // thresholds drop out, and writes to the unused indexes.
    write_reg(REG_MIN_BRIGHTNESS, 10'h3FF);
    write_thresholds(10'd800, 10'd400, 10'd900, 10'd100);
    write_reg(REG_SPARE_LO, 10'h3FF);
    write_reg(REG_SPARE_HI, 10'h3FF);
    pending_samples.push_back(10'h155);
    pending_samples.push_back(10'h2AA);
    pending_samples.push_back(10'd512);
    pending_samples.push_back(10'd900);
    wait_drained();
    phases_run++;

    // Enable bit low under a noisy data word: back to full brightness.
    write_reg(REG_SENSOR_ENABLE, 10'h3FE);
    pending_samples.push_back(10'd1023);
    pending_samples.push_back(10'd0);
    wait_drained();
    phases_run++;

    // Random phases; rotate the idle mix and the register setting.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 51; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 51; end
        default: begin idle_pct = 33; stall_pct = 33; end
      endcase
      if (phase == 0) begin
        style = CFG_ALL_LOW;
      end else if (phase == 1) begin
        style = CFG_ALL_HIGH;
      end else begin
        pick = $urandom_range(9);
        if (pick <= 5)      style = CFG_LADDER;
        else if (pick <= 7) style = CFG_SCRAMBLED;
        else if (pick == 8) style = CFG_DISABLED;
        else                style = $urandom_range(1) ? CFG_ALL_HIGH : CFG_ALL_LOW;
      end
      configure_dimmer(style);
      queue_samples(PHASE_ITEMS);
      wait_drained();
      phases_run++;
    end

    // Let any late word show up before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_words.size() != 0) begin
      $error("%0d predicted words never arrived", expected_words.size());
      errors++;
    end

    $display("run covered %0d sample words in, %0d result words out, %0d register writes",
             words_in, words_out, cfg_writes);
    $display("over %0d phases with mixed sender idling and receiver stalls, %0d mismatches",
             phases_run, errors);
    if (errors == 0) begin
      $display("tb_ambient_light_brightness_slew: PASS");
    end else begin
      $display("tb_ambient_light_brightness_slew: FAIL");
    end
    $finish;
  end

endmodule

@@ ambient_light_brightness_slew.f @@
design/albs_pkg.sv
design/albs_div.sv
design/ambient_light_brightness_slew.sv
design/albs_checker.sv
verif/tb_ambient_light_brightness_slew.sv
